// ===== design/rltt_pkg.sv =====
package rltt_pkg;

  localparam int LptW    = 13;
  localparam int LineW   = 12;
  localparam int PeriodW = 16;
  localparam int TurnW   = 32;
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 13;
  localparam int OutDataW = 40;
  localparam int DivCntW  = 5;

  localparam logic [CfgAddrW-1:0] CFG_LINES_PER_TURN = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_LINE_OFFSET    = 1'b1;

  localparam logic [0:0] FUNC_TICK = 1'b0;
  localparam logic [0:0] FUNC_EDGE = 1'b1;

  localparam logic [LptW-1:0]    LPT_RESET    = 13'd240;
  localparam logic [LineW-1:0]   FRONT_RESET  = 12'd120;
  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd30000;
  localparam logic [PeriodW-1:0] PERIOD_MAX   = 16'd65500;
  localparam logic [16:0]        FINE_LIMIT   = 17'd10;
  localparam logic [16:0]        COARSE_LIMIT = 17'd100;

  typedef struct packed {
    logic accept;
    logic tick;
    logic acc;
    logic div_step;
    logic update;
    logic load_out;
  } rltt_cmd_t;

endpackage

// ===== design/rotation_line_timing_tracker.sv =====
// Line timing tracker for a spinning display. A line tick (in_tuser = 0) goes
// through TICK and DONE; a sensor edge (in_tuser = 1) through ACC, the 32-step
// restoring divider that turns the turn time into a line period, one quotient
// bit per cycle, then UPD and DONE. One request is in flight at a time; the
// result sits in an output register, so the next request is taken while
// it waits. Configuration must be written only while idle; not enforced here.
module rotation_line_timing_tracker
  import rltt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // timer_count
  input  logic                in_tuser,   // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // period_cnt, front_line, back_line
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  rltt_cmd_t cmd;

  rltt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rltt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_count  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule

// ===== design/rltt_ctrl.sv =====
module rltt_ctrl
  import rltt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_func,
  output logic      out_tvalid,
  input  logic      out_tready,
  output rltt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_func == FUNC_EDGE) ? S_ACC : S_TICK;
        end
      end
      S_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = S_DONE;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DivCntW'(1);
        if (cnt_r == {DivCntW{1'b1}}) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/rltt_dp.sv =====
module rltt_dp
  import rltt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rltt_cmd_t           cmd,
  input  logic [PeriodW-1:0]  in_count,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output logic [OutDataW-1:0] out_data
);

  logic [LptW-1:0]     lpt_r;
  logic [LineW-1:0]    offset_r;
  logic [PeriodW-1:0]  count_r;
  logic [TurnW-1:0]    turn_r;
  logic [PeriodW-1:0]  period_r, period_nxt;
  logic [LineW-1:0]    front_r, front_nxt;
  logic [LineW-1:0]    back_r, back_nxt;
  logic [TurnW-1:0]    quo_r;
  logic [LptW-1:0]     rem_r;
  logic [OutDataW-1:0] out_r;

  logic [TurnW:0]   sum_edge, sum_tick;
  logic [TurnW-1:0] sat_edge, sat_tick;
  logic [LptW:0]    shifted;
  logic [LptW+1:0]  trial;
  logic [LptW-1:0]  adv_front, adv_back;
  logic [LptW-1:0]  front_raw, front_wrap;
  logic [PeriodW-1:0] q_clamp;
  logic [16:0]      delta;
  logic [21:0]      fine_sum, coarse_sum;

  assign sum_edge = {1'b0, turn_r} + {{(TurnW-PeriodW+1){1'b0}}, count_r};
  assign sum_tick = {1'b0, turn_r} + {{(TurnW-PeriodW+1){1'b0}}, period_r};
  assign sat_edge = sum_edge[TurnW] ? {TurnW{1'b1}} : sum_edge[TurnW-1:0];
  assign sat_tick = sum_tick[TurnW] ? {TurnW{1'b1}} : sum_tick[TurnW-1:0];

  assign shifted = {rem_r, quo_r[TurnW-1]};
  assign trial   = {1'b0, shifted} - {2'b0, lpt_r};

  function automatic logic [LineW-1:0] advance(input logic [LineW-1:0] c,
                                               input logic [LptW-1:0] lpt);
    logic [LptW-1:0] n;
    n = {1'b0, c} + LptW'(1);
    advance = (n >= lpt) ? '0 : n[LineW-1:0];
  endfunction

  assign adv_front  = {1'b0, advance(front_r, lpt_r)};
  assign adv_back   = {1'b0, advance(back_r, lpt_r)};
  assign front_raw  = {1'b0, offset_r} + {1'b0, lpt_r[LptW-1:1]};
  assign front_wrap = (front_raw >= lpt_r) ? (front_raw - lpt_r) : front_raw;

  assign q_clamp = (quo_r > {16'd0, PERIOD_MAX}) ? PERIOD_MAX : quo_r[PeriodW-1:0];
  assign delta   = ({1'b0, q_clamp} > {1'b0, period_r}) ?
                   ({1'b0, q_clamp} - {1'b0, period_r}) :
                   ({1'b0, period_r} - {1'b0, q_clamp});
  assign fine_sum   = {period_r, 6'd0} - {6'd0, period_r} + {6'd0, q_clamp};
  assign coarse_sum = {2'd0, period_r, 4'd0} - {6'd0, period_r} + {6'd0, q_clamp};

  always_comb begin
    period_nxt = period_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    if (cmd.tick) begin
      front_nxt = adv_front[LineW-1:0];
      back_nxt  = adv_back[LineW-1:0];
    end else if (cmd.update) begin
      if (delta < FINE_LIMIT) begin
        period_nxt = fine_sum[21:6];
      end else if (delta < COARSE_LIMIT) begin
        period_nxt = coarse_sum[19:4];
      end else begin
        period_nxt = q_clamp;
      end
      back_nxt  = offset_r;
      front_nxt = front_wrap[LineW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpt_r    <= LPT_RESET;
      offset_r <= '0;
      turn_r   <= '0;
      period_r <= PERIOD_RESET;
      front_r  <= FRONT_RESET;
      back_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LINES_PER_TURN: lpt_r    <= cfg_wdata;
          CFG_LINE_OFFSET:    offset_r <= cfg_wdata[LineW-1:0];
          default: ;
        endcase
      end
      if (cmd.tick) begin
        turn_r <= sat_tick;
      end else if (cmd.acc) begin
        turn_r <= sat_edge;
      end else if (cmd.update) begin
        turn_r <= '0;
      end
      period_r <= period_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count_r <= in_count;
    end
    if (cmd.acc) begin
      quo_r <= sat_edge;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[LptW+1]) begin
        rem_r <= trial[LptW-1:0];
        quo_r <= {quo_r[TurnW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[LptW-1:0];
        quo_r <= {quo_r[TurnW-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_r <= {back_r, front_r, period_r};
    end
  end

  assign out_data = out_r;

endmodule

// ===== design/rltt_checker.sv =====
module rltt_checker
  import rltt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] <= PERIOD_MAX)
    else $error("line period above limit");

endmodule

bind rotation_line_timing_tracker rltt_checker u_rltt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
